// ===== hw/rtl/klex_pkg.sv =====
// Shared types and constants for the keyword and operator lexer.
// Holds token kind codes, pending-token classes and the keyword tables.
// No dependencies.
package klex_pkg;

    // Token kind codes
    localparam int KIND_W = 6;

    localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd0;
    localparam logic [KIND_W-1:0] KIND_PLUS2   = 6'd10;
    localparam logic [KIND_W-1:0] KIND_PLUS    = 6'd11;
    localparam logic [KIND_W-1:0] KIND_MINUS2  = 6'd12;
    localparam logic [KIND_W-1:0] KIND_ARROW   = 6'd13;
    localparam logic [KIND_W-1:0] KIND_MINUS   = 6'd14;
    localparam logic [KIND_W-1:0] KIND_EQ2     = 6'd15;
    localparam logic [KIND_W-1:0] KIND_ASSIGN  = 6'd16;
    localparam logic [KIND_W-1:0] KIND_NE      = 6'd17;
    localparam logic [KIND_W-1:0] KIND_BANG    = 6'd18;
    localparam logic [KIND_W-1:0] KIND_GE      = 6'd19;
    localparam logic [KIND_W-1:0] KIND_GT      = 6'd20;
    localparam logic [KIND_W-1:0] KIND_LE      = 6'd21;
    localparam logic [KIND_W-1:0] KIND_LT      = 6'd22;
    localparam logic [KIND_W-1:0] KIND_STAR    = 6'd23;
    localparam logic [KIND_W-1:0] KIND_SLASH   = 6'd24;
    localparam logic [KIND_W-1:0] KIND_COLON   = 6'd25;
    localparam logic [KIND_W-1:0] KIND_HASH    = 6'd26;
    localparam logic [KIND_W-1:0] KIND_DOT     = 6'd27;
    localparam logic [KIND_W-1:0] KIND_COMMA   = 6'd28;
    localparam logic [KIND_W-1:0] KIND_SEMI    = 6'd29;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 6'd30;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 6'd31;
    localparam logic [KIND_W-1:0] KIND_LBRACK  = 6'd32;
    localparam logic [KIND_W-1:0] KIND_RBRACK  = 6'd33;
    localparam logic [KIND_W-1:0] KIND_LBRACE  = 6'd34;
    localparam logic [KIND_W-1:0] KIND_RBRACE  = 6'd35;
    localparam logic [KIND_W-1:0] KIND_EOF     = 6'd36;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 6'd37;

    // Token length field
    localparam int                LEN_W   = 16;
    localparam logic [LEN_W-1:0]  LEN_MAX = 16'hFFFF;

    // Results one source byte can cause, and the count width
    localparam int TOK_MAX   = 3;
    localparam int TOK_CNT_W = 2;

    // Special bytes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_US  = "_";

    // What is waiting for the next byte
    typedef enum logic [2:0] {
        PC_IDLE  = 3'd0,
        PC_TERM  = 3'd1,
        PC_PLUS  = 3'd2,
        PC_MINUS = 3'd3,
        PC_EQ    = 3'd4,
        PC_BANG  = 3'd5,
        PC_GT    = 3'd6,
        PC_LT    = 3'd7
    } pclass_t;

    // Keyword tables, first character at index 0
    localparam int KW_NUM = 9;

    localparam logic [7:0] KW_TEXT [KW_NUM][8] = '{
        '{"s", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "t", "r", "u", "c", "t", 8'h00, 8'h00},
        '{"n", "u", "m", "e", "r", "i", "c", 8'h00},
        '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "e", "l", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "i", "f", 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [KW_NUM] = '{
        3'd3, 3'd6, 3'd7, 3'd2, 3'd4, 3'd2, 3'd5, 3'd4, 3'd6
    };

endpackage

// ===== hw/rtl/klex_core.sv =====
// Lexer state and the single-pass step logic for one source byte.
// Produces up to three tokens per byte and the next lexer state.
// Depends on klex_pkg.
module klex_core import klex_pkg::*; #(
    parameter int OFFSET_BITS = 20,
    parameter int LINE_BITS   = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step,
    input  logic [7:0]                            char_byte,
    input  logic                                  end_of_source,
    output logic [TOK_MAX-1:0][KIND_W-1:0]        tok_kind,
    output logic [TOK_MAX-1:0][LINE_BITS-1:0]     tok_line,
    output logic [TOK_MAX-1:0][OFFSET_BITS-1:0]   tok_offset,
    output logic [TOK_MAX-1:0][LEN_W-1:0]         tok_length,
    output logic [TOK_CNT_W-1:0]                  tok_cnt
);

    // Character classes
    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    // Operators that may take a second byte
    function automatic pclass_t op_class(input logic [7:0] b);
        pclass_t pc;
        case (b)
            "+":     pc = PC_PLUS;
            "-":     pc = PC_MINUS;
            "=":     pc = PC_EQ;
            "!":     pc = PC_BANG;
            ">":     pc = PC_GT;
            "<":     pc = PC_LT;
            default: pc = PC_IDLE;
        endcase
        return pc;
    endfunction

    function automatic logic [KIND_W-1:0] single_kind(input pclass_t pc);
        logic [KIND_W-1:0] k;
        case (pc)
            PC_PLUS:  k = KIND_PLUS;
            PC_MINUS: k = KIND_MINUS;
            PC_EQ:    k = KIND_ASSIGN;
            PC_BANG:  k = KIND_BANG;
            PC_GT:    k = KIND_GT;
            PC_LT:    k = KIND_LT;
            default:  k = KIND_IDENT;
        endcase
        return k;
    endfunction

    // Two-byte operator kind, KIND_IDENT when the pair is not one
    function automatic logic [KIND_W-1:0] double_kind(input pclass_t pc,
                                                      input logic [7:0] b);
        logic [KIND_W-1:0] k;
        k = KIND_IDENT;
        case (pc)
            PC_PLUS: begin
                if (b == "+" || b == "=") k = KIND_PLUS2;
            end
            PC_MINUS: begin
                if (b == "-" || b == "=") k = KIND_MINUS2;
                else if (b == ">") k = KIND_ARROW;
            end
            PC_EQ:   if (b == "=") k = KIND_EQ2;
            PC_BANG: if (b == "=") k = KIND_NE;
            PC_GT:   if (b == "=") k = KIND_GE;
            PC_LT:   if (b == "=") k = KIND_LE;
            default: k = KIND_IDENT;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] plain_kind(input logic [7:0] b);
        logic [KIND_W-1:0] k;
        case (b)
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            ":":     k = KIND_COLON;
            "#":     k = KIND_HASH;
            ".":     k = KIND_DOT;
            ",":     k = KIND_COMMA;
            ";":     k = KIND_SEMI;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "[":     k = KIND_LBRACK;
            "]":     k = KIND_RBRACK;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // Keyword whose text still matches and whose length equals the term's
    function automatic logic [KIND_W-1:0] term_kind(input logic [KW_NUM-1:0] mask,
                                                    input logic [LEN_W-1:0] len);
        logic [KIND_W-1:0] k;
        k = KIND_IDENT;
        for (int i = 0; i < KW_NUM; i++) begin
            if (mask[i] && len == LEN_W'(KW_LEN[i])) k = KIND_W'(i + 1);
        end
        return k;
    endfunction

    pclass_t                  pc_reg, pc_next;
    logic [KW_NUM-1:0]        mask_reg, mask_next;
    logic [LEN_W-1:0]         tlen_reg, tlen_next;
    logic [OFFSET_BITS-1:0]   start_reg, start_next;
    logic [OFFSET_BITS-1:0]   off_reg, off_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;

    logic                     consumed;
    logic                     eof_done;
    logic [KIND_W-1:0]        dk;
    logic [TOK_CNT_W-1:0]     n;

    // Step: flush or extend the pending token, lex the byte, close the source
    always_comb begin
        pc_next    = pc_reg;
        mask_next  = mask_reg;
        tlen_next  = tlen_reg;
        start_next = start_reg;
        off_next   = off_reg;
        line_next  = line_reg;
        consumed   = 1'b0;
        eof_done   = 1'b0;
        dk         = KIND_IDENT;
        n          = '0;
        tok_kind   = '0;
        tok_line   = '0;
        tok_offset = '0;
        tok_length = '0;

        if (pc_reg == PC_TERM) begin
            if (is_alpha(char_byte) || is_digit(char_byte) || char_byte == CH_US) begin
                for (int i = 0; i < KW_NUM; i++) begin
                    if (!(tlen_reg < LEN_W'(KW_LEN[i]) &&
                          KW_TEXT[i][tlen_reg[2:0]] == char_byte)) begin
                        mask_next[i] = 1'b0;
                    end
                end
                if (tlen_reg != LEN_MAX) tlen_next = tlen_reg + 1'b1;
                consumed = 1'b1;
            end else begin
                tok_kind[n]   = term_kind(mask_reg, tlen_reg);
                tok_line[n]   = line_reg;
                tok_offset[n] = start_reg;
                tok_length[n] = tlen_reg;
                n             = n + 1'b1;
                pc_next       = PC_IDLE;
            end
        end else if (pc_reg != PC_IDLE) begin
            dk = double_kind(pc_reg, char_byte);
            tok_line[n]   = line_reg;
            tok_offset[n] = start_reg;
            if (dk != KIND_IDENT) begin
                tok_kind[n]   = dk;
                tok_length[n] = LEN_W'(2);
                consumed      = 1'b1;
            end else begin
                tok_kind[n]   = single_kind(pc_reg);
                tok_length[n] = LEN_W'(1);
            end
            n       = n + 1'b1;
            pc_next = PC_IDLE;
        end

        if (!consumed) begin
            if (char_byte == CH_NUL) begin
                tok_kind[n]   = KIND_EOF;
                tok_line[n]   = line_reg;
                tok_offset[n] = off_reg;
                tok_length[n] = '0;
                n             = n + 1'b1;
                eof_done      = 1'b1;
            end else if (is_space(char_byte)) begin
                if (char_byte == CH_NL && line_reg != '1) line_next = line_reg + 1'b1;
            end else if (is_alpha(char_byte)) begin
                pc_next    = PC_TERM;
                start_next = off_reg;
                tlen_next  = LEN_W'(1);
                for (int i = 0; i < KW_NUM; i++) begin
                    mask_next[i] = (KW_TEXT[i][0] == char_byte);
                end
            end else if (op_class(char_byte) != PC_IDLE) begin
                pc_next    = op_class(char_byte);
                start_next = off_reg;
            end else begin
                tok_kind[n]   = plain_kind(char_byte);
                tok_line[n]   = line_reg;
                tok_offset[n] = off_reg;
                tok_length[n] = LEN_W'(1);
                n             = n + 1'b1;
            end
        end

        if (off_reg != '1) off_next = off_reg + 1'b1;

        // Close the source after its final byte
        if (end_of_source && !eof_done) begin
            if (pc_next == PC_TERM) begin
                tok_kind[n]   = term_kind(mask_next, tlen_next);
                tok_line[n]   = line_next;
                tok_offset[n] = start_next;
                tok_length[n] = tlen_next;
                n             = n + 1'b1;
            end else if (pc_next != PC_IDLE) begin
                tok_kind[n]   = single_kind(pc_next);
                tok_line[n]   = line_next;
                tok_offset[n] = start_next;
                tok_length[n] = LEN_W'(1);
                n             = n + 1'b1;
            end
            tok_kind[n]   = KIND_EOF;
            tok_line[n]   = line_next;
            tok_offset[n] = off_next;
            tok_length[n] = '0;
            n             = n + 1'b1;
            eof_done      = 1'b1;
        end

        // Restart for the next source
        if (eof_done) begin
            pc_next    = PC_IDLE;
            mask_next  = '0;
            tlen_next  = '0;
            start_next = '0;
            off_next   = '0;
            line_next  = LINE_BITS'(1);
        end

        tok_cnt = n;
    end

    // Hold lexer state, advance on each step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg    <= PC_IDLE;
            mask_reg  <= '0;
            tlen_reg  <= '0;
            start_reg <= '0;
            off_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
        end else if (step) begin
            pc_reg    <= pc_next;
            mask_reg  <= mask_next;
            tlen_reg  <= tlen_next;
            start_reg <= start_next;
            off_reg   <= off_next;
            line_reg  <= line_next;
        end
    end

endmodule

// ===== hw/rtl/klex_out.sv =====
// Result register for the tokens of one byte and the serializer that hands them to
// the m_ channel one word per cycle while m_tready is high. Depends on klex_pkg.
module klex_out import klex_pkg::*; #(
    parameter int OFFSET_BITS = 20,
    parameter int LINE_BITS   = 16,
    parameter int TDATA_W     = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load,
    output logic                                  load_ok,
    input  logic [TOK_MAX-1:0][KIND_W-1:0]        tok_kind,
    input  logic [TOK_MAX-1:0][LINE_BITS-1:0]     tok_line,
    input  logic [TOK_MAX-1:0][OFFSET_BITS-1:0]   tok_offset,
    input  logic [TOK_MAX-1:0][LEN_W-1:0]         tok_length,
    input  logic [TOK_CNT_W-1:0]                  tok_cnt,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [TDATA_W-1:0]                    m_tdata,
    output logic                                  m_tlast
);

    logic [TOK_MAX-1:0][KIND_W-1:0]        kind_reg;
    logic [TOK_MAX-1:0][LINE_BITS-1:0]     line_reg;
    logic [TOK_MAX-1:0][OFFSET_BITS-1:0]   off_reg;
    logic [TOK_MAX-1:0][LEN_W-1:0]         len_reg;
    logic [TOK_CNT_W-1:0]                  cnt_reg;
    logic [TOK_CNT_W-1:0]                  idx_reg;
    logic                                  on_last;

    // Status of the held group
    assign m_tvalid = (idx_reg != cnt_reg);
    assign on_last  = ((idx_reg + 1'b1) == cnt_reg);
    assign m_tlast  = on_last;
    assign load_ok  = (idx_reg == cnt_reg) || (m_tready && on_last);

    // Pack the current word, kind in the lowest bits
    assign m_tdata = TDATA_W'({len_reg[idx_reg], off_reg[idx_reg],
                               line_reg[idx_reg], kind_reg[idx_reg]});

    // Counters: load a new group or advance past a taken word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else if (load) begin
            cnt_reg <= tok_cnt;
            idx_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Token payload
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= tok_kind;
            line_reg <= tok_line;
            off_reg  <= tok_offset;
            len_reg  <= tok_length;
        end
    end

endmodule

// ===== hw/rtl/keyword_operator_lexer.sv =====
// Keyword and operator lexer, top level: input word register and wiring
// of the step logic and the output serializer.
// Depends on klex_pkg, klex_core and klex_out.
//
// Use: feed source text one byte per word on the s_ channel; s_tlast marks
// the final byte of a source, and a zero byte also ends the source. Tokens
// leave on the m_ channel, one per word, m_tlast on the last token that a
// given byte caused. A byte causes zero to three tokens.
// A byte taken on s_ passes the input register, then its tokens the result
// register. Throughput: one byte per cycle while each byte causes at most
// one token and m_tready is high; a byte that causes more holds the input
// while the serializer sends its tokens, one per cycle while m_tready is high.
// The input register keeps taking a byte while a finished token waits.
// Reset clears the lexer to line 1, offset 0, nothing pending, and empties
// both registers. When the receiver stalls, the held token stays on m_tdata
// and the input stops once the input register holds a byte.
// After each end of source the lexer restarts at line 1, offset 0.
module keyword_operator_lexer import klex_pkg::*; #(
    parameter int OFFSET_BITS = 20,
    parameter int LINE_BITS   = 16,
    localparam int M_TDATA_W  = ((KIND_W + LINE_BITS + OFFSET_BITS + LEN_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] char_byte
    input  logic                  s_tlast,   // end_of_source
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, lowest first: token_kind, token_line, token_offset,
    // token_length, zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast    // last_of_run
);

    logic                                  in_valid_reg;
    logic [7:0]                            in_byte_reg;
    logic                                  in_eos_reg;
    logic                                  step;
    logic                                  load_ok;
    logic [TOK_MAX-1:0][KIND_W-1:0]        tok_kind;
    logic [TOK_MAX-1:0][LINE_BITS-1:0]     tok_line;
    logic [TOK_MAX-1:0][OFFSET_BITS-1:0]   tok_offset;
    logic [TOK_MAX-1:0][LEN_W-1:0]         tok_length;
    logic [TOK_CNT_W-1:0]                  tok_cnt;

    // Lex the held byte when the result register can take its tokens
    assign step     = in_valid_reg && load_ok;
    assign s_tready = !in_valid_reg || step;

    // Input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

    klex_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .char_byte     (in_byte_reg),
        .end_of_source (in_eos_reg),
        .tok_kind      (tok_kind),
        .tok_line      (tok_line),
        .tok_offset    (tok_offset),
        .tok_length    (tok_length),
        .tok_cnt       (tok_cnt)
    );

    klex_out #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .TDATA_W     (M_TDATA_W)
    ) u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (step),
        .load_ok    (load_ok),
        .tok_kind   (tok_kind),
        .tok_line   (tok_line),
        .tok_offset (tok_offset),
        .tok_length (tok_length),
        .tok_cnt    (tok_cnt),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
